@@ rtl/cba_pkg.sv @@
// Shared types, codes and tactic tables of the cache budget allocator.
`default_nettype none
package cba_pkg;
   localparam int SLOT_AW = 8;
   localparam int USED_W  = 32;
   localparam int TICK_W  = 32;
   localparam int CAP_W   = 37;
   localparam int LIMIT_W = 36;
   localparam int THR_W   = 16;
   localparam int MAX_RES = 16;

   localparam logic [3:0] FN_ADD       = 4'd0;
   localparam logic [3:0] FN_REMOVE    = 4'd1;
   localparam logic [3:0] FN_ACTIVITY  = 4'd2;
   localparam logic [3:0] FN_SIZE      = 4'd3;
   localparam logic [3:0] FN_TICK      = 4'd4;
   localparam logic [3:0] FN_REVISE    = 4'd5;
   localparam logic [3:0] FN_CLEAR_ALL = 4'd6;
   localparam logic [3:0] FN_CLEAR_NAV = 4'd7;
   localparam logic [3:0] FN_CLEAR_ONE = 4'd8;

   localparam logic [1:0] KD_ACK      = 2'd0;
   localparam logic [1:0] KD_SET_CAP  = 2'd1;
   localparam logic [1:0] KD_CLR_INST = 2'd2;
   localparam logic [1:0] KD_CLR_NAV  = 2'd3;

   localparam logic REG_GLOBAL_LIMIT   = 1'b0;
   localparam logic REG_IDLE_THRESHOLD = 1'b1;

   localparam logic [1:0] TAC_EVEN = 2'd0;
   localparam logic [1:0] TAC_KEEP = 2'd1;
   localparam logic [1:0] TAC_HEAD = 2'd2;

   typedef struct packed {
      logic                 rd_en;
      logic                 wr_used;
      logic                 wr_touch;
      logic                 wr_cap;
      logic [SLOT_AW-1:0]   addr;
      logic [USED_W-1:0]    used;
      logic [TICK_W-1:0]    touch;
      logic [CAP_W-1:0]     cap;
   } mem_req_type;

   typedef struct packed {
      logic [USED_W-1:0]    used;
      logic [TICK_W-1:0]    touch;
      logic [CAP_W-1:0]     cap;
   } mem_rd_type;

   function automatic logic [1:0] act_tac(input logic [1:0] t);
      logic [1:0] r;
      case (t)
         2'd0:    r = TAC_HEAD;
         2'd1:    r = TAC_HEAD;
         2'd2:    r = TAC_KEEP;
         default: r = TAC_EVEN;
      endcase
      return r;
   endfunction

   function automatic logic [1:0] ina_tac(input logic [1:0] t);
      logic [1:0] r;
      case (t)
         2'd0:    r = TAC_KEEP;
         default: r = TAC_EVEN;
      endcase
      return r;
   endfunction
endpackage
`default_nettype wire

@@ rtl/cba_mem.sv @@
// Slot record memory: used bytes, last touch and sent capacity, one read port.
`default_nettype none
module cba_mem #(
   parameter int DEPTH = 16
) (
   input  wire logic               clock,
   input  wire cba_pkg::mem_req_type req,
   output      cba_pkg::mem_rd_type  rd
);
   import cba_pkg::*;

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   mem_rd_type mem [DEPTH];
   mem_rd_type rd_ff;

   always_ff @(posedge clock) begin
      if (req.wr_used) begin
         mem[req.addr[AW-1:0]].used <= req.used;
      end
      if (req.wr_touch) begin
         mem[req.addr[AW-1:0]].touch <= req.touch;
      end
      if (req.wr_cap) begin
         mem[req.addr[AW-1:0]].cap <= req.cap;
      end
      if (req.rd_en) begin
         rd_ff <= mem[req.addr[AW-1:0]];
      end
   end

   assign rd = rd_ff;
endmodule
`default_nettype wire

@@ rtl/cba_div.sv @@
// Restoring divider, one quotient bit per cycle.
`default_nettype none
module cba_div #(
   parameter int NW = 36,
   parameter int DW = 5
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          start,
   input  wire logic [NW-1:0] num,
   input  wire logic [DW-1:0] den,
   output      logic          busy,
   output      logic          done,
   output      logic [NW-1:0] quot
);
   localparam int CNW = $clog2(NW + 1);

   logic [DW-1:0]  rem_ff;
   logic [NW-1:0]  q_ff;
   logic [DW-1:0]  den_ff;
   logic [CNW-1:0] cnt_ff;
   logic           busy_ff;
   logic           done_ff;
   logic [DW:0]    sh;
   logic           ge;

   assign sh = {rem_ff, q_ff[NW-1]};
   assign ge = sh >= {1'b0, den_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
            rem_ff  <= '0;
            q_ff    <= num;
            den_ff  <= den;
         end else if (busy_ff) begin
            rem_ff <= ge ? DW'(sh - {1'b0, den_ff}) : sh[DW-1:0];
            q_ff   <= {q_ff[NW-2:0], ge};
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == CNW'(NW - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign busy = busy_ff;
   assign done = done_ff;
   assign quot = q_ff;
endmodule
`default_nettype wire

@@ rtl/cache_budget_allocator_top.sv @@
// Cache budget allocator: slot sequencer, budget revision and result channel.
//
// Usage: items enter on the req_ stream (func in req_tuser), results leave on
// the rsp_ stream (kind in rsp_tuser, tlast on the final result of an item).
// Registers must be written on the csr_ port only while the block is idle;
// the block itself does not enforce this. One item is worked on at a time;
// req_tready is high only between items. Add, remove, activity, size report,
// tick and clear one update state and finish; clear all and clear on
// navigation visit every slot; revise demotes and sums each slot, makes up to
// 4 tactic checks and up to three divisions, then reads each valid slot of
// the active group and then the idle group and issues the changed capacities.
// The slot record memory is read and written one slot at a time with one read
// per visit, so no two accesses to an entry overlap.
// A result is held in a one-deep stage ahead of the output register so tlast
// is known; when the output register is full and rsp_tready is low the walk pauses at the next result.
// Reset clears all slots, ticks and the pending flag, and restores the
// register defaults; the record memory needs no clearing pass.
`default_nettype none
module cache_budget_allocator_top #(
   parameter int MAX_CLIENTS = 16
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output      logic        req_tready,
   input  wire logic [39:0] req_tdata,   // client_slot, reported_size, zero pad
   input  wire logic [3:0]  req_tuser,   // func
   output      logic        rsp_tvalid,
   input  wire logic        rsp_tready,
   output      logic [47:0] rsp_tdata,   // target_slot, capacity, revise_pending, pad
   output      logic [1:0]  rsp_tuser,   // kind
   output      logic        rsp_tlast,
   input  wire logic        csr_we,
   input  wire logic        csr_index,
   input  wire logic [35:0] csr_wdata
);
   import cba_pkg::*;

   localparam int SW   = (MAX_CLIENTS > 1) ? $clog2(MAX_CLIENTS) : 1;
   localparam int CW   = SW + 1;
   localparam int SUMW = USED_W + SW;
   localparam int RW   = SUMW + 2;
   localparam logic [SW-1:0] LAST_IDX = SW'(MAX_CLIENTS - 1);
   localparam logic [8:0]    MAX9     = 9'(MAX_CLIENTS);

   localparam logic [3:0] ST_IDLE  = 4'd0;
   localparam logic [3:0] ST_DM_RD = 4'd1;
   localparam logic [3:0] ST_DM_EV = 4'd2;
   localparam logic [3:0] ST_TACT  = 4'd3;
   localparam logic [3:0] ST_DV_GO = 4'd4;
   localparam logic [3:0] ST_DV_WT = 4'd5;
   localparam logic [3:0] ST_GV_RD = 4'd6;
   localparam logic [3:0] ST_GV_EV = 4'd7;
   localparam logic [3:0] ST_CLR   = 4'd8;
   localparam logic [3:0] ST_FIN   = 4'd9;

   function automatic logic [RW-1:0] reserve(input logic [1:0] t, input logic [RW-1:0] x);
      logic [RW-1:0] x3;
      logic [RW-1:0] r;
      x3 = x + (x << 1);
      case (t)
         TAC_HEAD: r = x3 >> 1;
         TAC_KEEP: r = x;
         default:  r = '0;
      endcase
      return r;
   endfunction

   logic [3:0]             st_ff;
   logic [SW-1:0]          idx_ff;
   logic                   grp_ff;
   logic [1:0]             tac_ff;
   logic [1:0]             dsel_ff;
   logic [3:0]             op_ff;
   logic [3:0]             slot_ff;
   logic [MAX_CLIENTS-1:0] valid_ff;
   logic [MAX_CLIENTS-1:0] active_ff;
   logic [MAX_CLIENTS-1:0] known_ff;
   logic [TICK_W-1:0]      now_ff;
   logic                   pend_ff;
   logic [LIMIT_W-1:0]     limit_ff;
   logic [THR_W-1:0]       thr_ff;
   logic [SUMW-1:0]        asum_ff;
   logic [SUMW-1:0]        isum_ff;
   logic [CW-1:0]          acnt_ff;
   logic [CW-1:0]          icnt_ff;
   logic [LIMIT_W-1:0]     total_ff;
   logic [LIMIT_W-1:0]     iext_ff;
   logic [LIMIT_W-1:0]     each_a_ff;
   logic [LIMIT_W-1:0]     each_i_ff;
   logic                   hld_valid_ff;
   logic [1:0]             hld_kind_ff;
   logic [3:0]             hld_slot_ff;
   logic [CAP_W-1:0]       hld_cap_ff;
   logic [4:0]             ecnt_ff;
   logic                   out_valid_ff;
   logic [1:0]             out_kind_ff;
   logic [3:0]             out_slot_ff;
   logic [CAP_W-1:0]       out_cap_ff;
   logic                   out_pend_ff;
   logic                   out_last_ff;

   mem_req_type      mreq;
   mem_rd_type       mrd;
   logic             accept;
   logic [3:0]       in_func;
   logic [3:0]       in_slot;
   logic [USED_W-1:0] in_size;
   logic [8:0]       slot9;
   logic             slot_ok;
   logic [SW-1:0]    in_idx;
   logic             out_free;
   logic             out_load;
   logic             emit_want;
   logic             emit_go;
   logic             stall;
   logic [1:0]       emit_kind;
   logic [CAP_W-1:0] gv_cap;
   logic             gv_upd;
   logic             gv_hit;
   logic [RW-1:0]    ra;
   logic [RW-1:0]    ri;
   logic [RW:0]      rsum;
   logic             fits;
   logic             idle_hit;
   logic             act_new;
   logic             div_need;
   logic             div_start;
   logic             div_busy;
   logic             div_done;
   logic [LIMIT_W-1:0] div_num;
   logic [CW-1:0]    div_den;
   logic [LIMIT_W-1:0] div_q;

   assign in_func  = req_tuser;
   assign in_slot  = req_tdata[3:0];
   assign in_size  = req_tdata[35:4];
   assign slot9    = {5'b0, in_slot};
   assign slot_ok  = slot9 < MAX9;
   assign in_idx   = slot9[SW-1:0];
   assign req_tready = (st_ff == ST_IDLE);
   assign accept   = req_tvalid && req_tready;
   assign out_free = !out_valid_ff || rsp_tready;

   assign ra   = reserve(act_tac(tac_ff), RW'(asum_ff));
   assign ri   = reserve(ina_tac(tac_ff), RW'(isum_ff));
   assign rsum = {1'b0, ra} + {1'b0, ri};
   assign fits = (RW + 1)'(limit_ff) >= rsum;

   assign idle_hit = (now_ff - mrd.touch) >= {16'b0, thr_ff};
   assign act_new  = active_ff[idx_ff] && !idle_hit;

   assign gv_cap = CAP_W'(grp_ff ? each_a_ff : each_i_ff)
                 + CAP_W'(reserve(grp_ff ? act_tac(tac_ff) : ina_tac(tac_ff), RW'(mrd.used)));
   assign gv_hit = known_ff[idx_ff] && (mrd.cap == gv_cap);
   assign gv_upd = !gv_hit;

   always_comb begin
      emit_want = 1'b0;
      emit_kind = KD_SET_CAP;
      case (st_ff)
         ST_GV_EV: emit_want = gv_upd && (ecnt_ff < 5'(MAX_RES));
         ST_CLR: begin
            emit_want = valid_ff[idx_ff] && (ecnt_ff < 5'(MAX_RES));
            emit_kind = (op_ff == FN_CLEAR_ALL) ? KD_CLR_INST : KD_CLR_NAV;
         end
         default: emit_want = 1'b0;
      endcase
   end

   assign stall    = emit_want && hld_valid_ff && !out_free;
   assign emit_go  = emit_want && !stall;
   assign out_load = (emit_go && hld_valid_ff) || ((st_ff == ST_FIN) && out_free);

   always_comb begin
      case (dsel_ff)
         2'd0: begin
            div_need = icnt_ff != '0;
            div_num  = total_ff;
            div_den  = acnt_ff + CW'(icnt_ff != '0);
         end
         2'd1: begin
            div_need = acnt_ff != '0;
            div_num  = total_ff - iext_ff;
            div_den  = acnt_ff;
         end
         default: begin
            div_need = icnt_ff != '0;
            div_num  = iext_ff;
            div_den  = icnt_ff;
         end
      endcase
   end

   assign div_start = (st_ff == ST_DV_GO) && div_need;

   always_comb begin
      mreq = '0;
      case (st_ff)
         ST_IDLE: begin
            mreq.addr  = SLOT_AW'(in_idx);
            mreq.used  = (in_func == FN_SIZE) ? in_size : '0;
            mreq.touch = now_ff;
            if (accept && slot_ok) begin
               case (in_func)
                  FN_ADD: begin
                     mreq.wr_used  = 1'b1;
                     mreq.wr_touch = 1'b1;
                  end
                  FN_ACTIVITY: mreq.wr_touch = valid_ff[in_idx];
                  FN_SIZE:     mreq.wr_used  = valid_ff[in_idx];
                  default:     mreq.wr_used  = 1'b0;
               endcase
            end
         end
         ST_DM_RD: begin
            mreq.addr  = SLOT_AW'(idx_ff);
            mreq.rd_en = 1'b1;
         end
         ST_GV_RD: begin
            mreq.addr  = SLOT_AW'(idx_ff);
            mreq.rd_en = valid_ff[idx_ff] && (active_ff[idx_ff] == grp_ff);
         end
         ST_GV_EV: begin
            mreq.addr   = SLOT_AW'(idx_ff);
            mreq.cap    = gv_cap;
            mreq.wr_cap = gv_upd && !stall;
         end
         default: mreq = '0;
      endcase
   end

   cba_mem #(
      .DEPTH(MAX_CLIENTS)
   ) u_mem (
      .clock(clock),
      .req  (mreq),
      .rd   (mrd)
   );

   cba_div #(
      .NW(LIMIT_W),
      .DW(CW)
   ) u_div (
      .clock(clock),
      .reset(reset),
      .start(div_start),
      .num  (div_num),
      .den  (div_den),
      .busy (div_busy),
      .done (div_done),
      .quot (div_q)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff        <= ST_IDLE;
         valid_ff     <= '0;
         active_ff    <= '0;
         known_ff     <= '0;
         now_ff       <= '0;
         pend_ff      <= 1'b0;
         limit_ff     <= LIMIT_W'(8 * 1024 * 1024);
         thr_ff       <= THR_W'(5);
         hld_valid_ff <= 1'b0;
         ecnt_ff      <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               REG_GLOBAL_LIMIT: begin
                  limit_ff <= csr_wdata;
                  pend_ff  <= 1'b1;
               end
               default: thr_ff <= csr_wdata[THR_W-1:0];
            endcase
         end

         if (out_valid_ff && rsp_tready && !out_load) begin
            out_valid_ff <= 1'b0;
         end

         if (emit_go) begin
            if (hld_valid_ff) begin
               out_valid_ff <= 1'b1;
               out_kind_ff  <= hld_kind_ff;
               out_slot_ff  <= hld_slot_ff;
               out_cap_ff   <= hld_cap_ff;
               out_pend_ff  <= pend_ff;
               out_last_ff  <= 1'b0;
            end
            hld_valid_ff <= 1'b1;
            hld_kind_ff  <= emit_kind;
            hld_slot_ff  <= 4'(idx_ff);
            hld_cap_ff   <= (st_ff == ST_GV_EV) ? gv_cap : '0;
            ecnt_ff      <= ecnt_ff + 1'b1;
         end

         case (st_ff)
            ST_IDLE: begin
               if (accept) begin
                  op_ff   <= in_func;
                  slot_ff <= in_slot;
                  idx_ff  <= '0;
                  case (in_func)
                     FN_ADD: begin
                        if (slot_ok) begin
                           valid_ff[in_idx]  <= 1'b1;
                           active_ff[in_idx] <= 1'b1;
                           known_ff[in_idx]  <= 1'b0;
                           pend_ff           <= 1'b1;
                        end
                        st_ff <= ST_FIN;
                     end
                     FN_REMOVE: begin
                        if (slot_ok) begin
                           valid_ff[in_idx]  <= 1'b0;
                           active_ff[in_idx] <= 1'b0;
                           known_ff[in_idx]  <= 1'b0;
                           pend_ff           <= 1'b1;
                        end
                        st_ff <= ST_FIN;
                     end
                     FN_ACTIVITY: begin
                        if (slot_ok && valid_ff[in_idx] && !active_ff[in_idx]) begin
                           active_ff[in_idx] <= 1'b1;
                           pend_ff           <= 1'b1;
                        end
                        st_ff <= ST_FIN;
                     end
                     FN_TICK: begin
                        now_ff <= now_ff + 1'b1;
                        st_ff  <= ST_FIN;
                     end
                     FN_REVISE: begin
                        pend_ff <= 1'b0;
                        asum_ff <= '0;
                        isum_ff <= '0;
                        acnt_ff <= '0;
                        icnt_ff <= '0;
                        st_ff   <= ST_DM_RD;
                     end
                     FN_CLEAR_ALL, FN_CLEAR_NAV: st_ff <= ST_CLR;
                     FN_CLEAR_ONE: begin
                        if (slot_ok && valid_ff[in_idx]) begin
                           hld_valid_ff <= 1'b1;
                           hld_kind_ff  <= KD_CLR_INST;
                           hld_slot_ff  <= in_slot;
                           hld_cap_ff   <= '0;
                           ecnt_ff      <= 5'd1;
                        end
                        st_ff <= ST_FIN;
                     end
                     default: st_ff <= ST_FIN;
                  endcase
               end
            end
            ST_DM_RD: st_ff <= ST_DM_EV;
            ST_DM_EV: begin
               if (valid_ff[idx_ff]) begin
                  active_ff[idx_ff] <= act_new;
                  if (act_new) begin
                     asum_ff <= asum_ff + SUMW'(mrd.used);
                     acnt_ff <= acnt_ff + 1'b1;
                  end else begin
                     isum_ff <= isum_ff + SUMW'(mrd.used);
                     icnt_ff <= icnt_ff + 1'b1;
                  end
               end
               if (idx_ff == LAST_IDX) begin
                  tac_ff <= 2'd0;
                  st_ff  <= ST_TACT;
               end else begin
                  idx_ff <= idx_ff + 1'b1;
                  st_ff  <= ST_DM_RD;
               end
            end
            ST_TACT: begin
               if (fits) begin
                  total_ff <= LIMIT_W'((RW + 1)'(limit_ff) - rsum);
                  dsel_ff  <= 2'd0;
                  st_ff    <= ST_DV_GO;
               end else if (tac_ff == 2'd3) begin
                  st_ff <= ST_FIN;
               end else begin
                  tac_ff <= tac_ff + 1'b1;
               end
            end
            ST_DV_GO: begin
               if (div_need) begin
                  st_ff <= ST_DV_WT;
               end else begin
                  if (dsel_ff == 2'd0) begin
                     iext_ff <= '0;
                  end
                  if (dsel_ff == 2'd2) begin
                     idx_ff <= '0;
                     grp_ff <= 1'b1;
                     st_ff  <= ST_GV_RD;
                  end else begin
                     dsel_ff <= dsel_ff + 1'b1;
                  end
               end
            end
            ST_DV_WT: begin
               if (div_done) begin
                  case (dsel_ff)
                     2'd0:    iext_ff   <= div_q;
                     2'd1:    each_a_ff <= div_q;
                     default: each_i_ff <= div_q;
                  endcase
                  if (dsel_ff == 2'd2) begin
                     idx_ff <= '0;
                     grp_ff <= 1'b1;
                     st_ff  <= ST_GV_RD;
                  end else begin
                     dsel_ff <= dsel_ff + 1'b1;
                     st_ff   <= ST_DV_GO;
                  end
               end
            end
            ST_GV_RD: begin
               if (mreq.rd_en) begin
                  st_ff <= ST_GV_EV;
               end else if (idx_ff != LAST_IDX) begin
                  idx_ff <= idx_ff + 1'b1;
               end else if (grp_ff) begin
                  grp_ff <= 1'b0;
                  idx_ff <= '0;
               end else begin
                  st_ff <= ST_FIN;
               end
            end
            ST_GV_EV: begin
               if (!stall) begin
                  if (gv_upd) begin
                     known_ff[idx_ff] <= 1'b1;
                  end
                  if (idx_ff != LAST_IDX) begin
                     idx_ff <= idx_ff + 1'b1;
                     st_ff  <= ST_GV_RD;
                  end else if (grp_ff) begin
                     grp_ff <= 1'b0;
                     idx_ff <= '0;
                     st_ff  <= ST_GV_RD;
                  end else begin
                     st_ff <= ST_FIN;
                  end
               end
            end
            ST_CLR: begin
               if (!stall) begin
                  if (idx_ff == LAST_IDX) begin
                     st_ff <= ST_FIN;
                  end else begin
                     idx_ff <= idx_ff + 1'b1;
                  end
               end
            end
            ST_FIN: begin
               if (out_free) begin
                  out_valid_ff <= 1'b1;
                  out_kind_ff  <= hld_valid_ff ? hld_kind_ff : KD_ACK;
                  out_slot_ff  <= hld_valid_ff ? hld_slot_ff : slot_ff;
                  out_cap_ff   <= hld_valid_ff ? hld_cap_ff : '0;
                  out_pend_ff  <= pend_ff;
                  out_last_ff  <= 1'b1;
                  hld_valid_ff <= 1'b0;
                  ecnt_ff      <= '0;
                  st_ff        <= ST_IDLE;
               end
            end
            default: st_ff <= ST_IDLE;
         endcase
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {6'b0, out_pend_ff, out_cap_ff, out_slot_ff};
   assign rsp_tuser  = out_kind_ff;
   assign rsp_tlast  = out_last_ff;

   a_div_idle_start: assert property (@(posedge clock) disable iff (reset)
      div_start |-> !div_busy)
      else $error("divider restarted while busy");

   a_hold_empty_idle: assert property (@(posedge clock) disable iff (reset)
      (st_ff == ST_IDLE) |-> !hld_valid_ff)
      else $error("held result left over between items");

   a_result_cap: assert property (@(posedge clock) disable iff (reset)
      ecnt_ff <= 5'(MAX_RES))
      else $error("too many results for one item");

   a_leave_idle: assert property (@(posedge clock) disable iff (reset)
      accept |=> (st_ff != ST_IDLE))
      else $error("accepted transfer not processed");
endmodule
`default_nettype wire
